### src/transfer_session_sender_assert.svh
// assertion macros for the transfer session sender
`ifndef TRANSFER_SESSION_SENDER_ASSERT_SVH
`define TRANSFER_SESSION_SENDER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define TSND_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TSND_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/tsnd_pkg.sv
// shared types, codes and helpers for the transfer session sender
package tsnd_pkg;

    localparam int unsigned SESSION_W = 32;
    localparam int unsigned COUNT_W   = 16;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned STEP_W    = 3;
    localparam int unsigned OUTCOME_W = 3;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_START        = 3'd0,
        OP_SOURCE_READY = 3'd1,
        OP_RETRY        = 3'd2,
        OP_FRAME_SENT   = 3'd3,
        OP_ACK          = 3'd4
    } op_t;

    typedef enum logic [STEP_W-1:0] {
        STEP_RESET       = 3'd0,
        STEP_WAIT_SOURCE = 3'd1,
        STEP_ENTRY       = 3'd2,
        STEP_DONE        = 3'd3,
        STEP_ACK_PENDING = 3'd4,
        STEP_COMPLETE    = 3'd5
    } step_t;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_NONE     = 3'd0,
        OUT_REFUSED  = 3'd1,
        OUT_IGNORED  = 3'd2,
        OUT_COMPLETE = 3'd3,
        OUT_RETRY    = 3'd4
    } outcome_t;

    typedef struct packed {
        logic [COUNT_W-1:0]   ack_count;
        logic                 ack_accepted;
        logic                 source_is_ready;
        logic [SESSION_W-1:0] session_id;
        logic [OP_W-1:0]      op;
    } event_t;

    typedef struct packed {
        outcome_t           event_outcome;
        logic [COUNT_W-1:0] next_index;
        step_t              send_step;
    } result_t;

    // entry step reads as done once the counter has reached the total
    function automatic step_t eff_step(input step_t step, input logic [COUNT_W-1:0] count,
                                       input logic [COUNT_W-1:0] total);
        step_t s;
        s = step;
        if (step == STEP_ENTRY && count >= total)
        begin
            s = STEP_DONE;
        end
        return s;
    endfunction

endpackage

### src/tsnd_in_stage.sv
// input register: holds one accepted event word until the core takes it
module tsnd_in_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tsnd_pkg::event_t in_event,
    output logic             ev_valid,
    input  logic             ev_take,
    output tsnd_pkg::event_t ev
);

    logic             valid_reg;
    tsnd_pkg::event_t event_reg;

    assign in_ready = !valid_reg || ev_take;
    assign ev_valid = valid_reg;
    assign ev       = event_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            event_reg <= in_event;
        end
    end

endmodule

### src/tsnd_core.sv
// session state, event decode and result register
`include "transfer_session_sender_assert.svh"

module tsnd_core (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wen,
    input  logic [tsnd_pkg::COUNT_W-1:0]     cfg_wdata,
    input  logic                             ev_valid,
    output logic                             ev_take,
    input  tsnd_pkg::event_t                 ev,
    output logic                             res_valid,
    input  logic                             res_ready,
    output tsnd_pkg::result_t                res
);

    logic [tsnd_pkg::COUNT_W-1:0]   total_reg;
    logic [tsnd_pkg::SESSION_W-1:0] session_reg, session_next;
    logic [tsnd_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic                           ready_reg, ready_next;
    tsnd_pkg::step_t                step_reg, step_next;
    tsnd_pkg::outcome_t             outcome_next;
    tsnd_pkg::step_t                eff_now;
    logic [tsnd_pkg::COUNT_W-1:0]   count_inc;
    logic                           res_valid_reg;
    tsnd_pkg::result_t              res_reg, res_next;

    assign ev_take   = ev_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign eff_now   = tsnd_pkg::eff_step(step_reg, count_reg, total_reg);
    assign count_inc = count_reg + 1'b1;

    // next state
    always_comb
    begin
        session_next = session_reg;
        count_next   = count_reg;
        ready_next   = ready_reg;
        step_next    = step_reg;
        outcome_next = tsnd_pkg::OUT_NONE;
        unique case (ev.op)
            tsnd_pkg::OP_START:
            begin
                if (ev.session_id == '0)
                begin
                    outcome_next = tsnd_pkg::OUT_REFUSED;
                end
                else
                begin
                    session_next = ev.session_id;
                    count_next   = '0;
                    ready_next   = ev.source_is_ready;
                    step_next    = tsnd_pkg::STEP_RESET;
                end
            end
            tsnd_pkg::OP_SOURCE_READY:
            begin
                ready_next = 1'b1;
                if (step_reg == tsnd_pkg::STEP_WAIT_SOURCE)
                begin
                    step_next = tsnd_pkg::STEP_ENTRY;
                end
            end
            tsnd_pkg::OP_RETRY:
            begin
                if (session_reg != '0)
                begin
                    count_next = '0;
                    step_next  = tsnd_pkg::STEP_RESET;
                end
            end
            tsnd_pkg::OP_FRAME_SENT:
            begin
                unique case (eff_now)
                    tsnd_pkg::STEP_RESET:
                    begin
                        step_next = ready_reg ? tsnd_pkg::STEP_ENTRY
                                              : tsnd_pkg::STEP_WAIT_SOURCE;
                    end
                    tsnd_pkg::STEP_ENTRY:
                    begin
                        count_next = count_inc;
                        step_next  = (count_inc >= total_reg) ? tsnd_pkg::STEP_DONE
                                                              : tsnd_pkg::STEP_ENTRY;
                    end
                    tsnd_pkg::STEP_DONE:
                    begin
                        step_next = tsnd_pkg::STEP_ACK_PENDING;
                    end
                    default:
                    begin
                        step_next = step_reg;
                    end
                endcase
            end
            tsnd_pkg::OP_ACK:
            begin
                if (step_reg != tsnd_pkg::STEP_ACK_PENDING || ev.session_id != session_reg)
                begin
                    outcome_next = tsnd_pkg::OUT_IGNORED;
                end
                else if (ev.ack_accepted && ev.ack_count == total_reg)
                begin
                    step_next    = tsnd_pkg::STEP_COMPLETE;
                    outcome_next = tsnd_pkg::OUT_COMPLETE;
                end
                else
                begin
                    // awaiting the acknowledgement implies a live session, so this always restarts
                    count_next   = '0;
                    step_next    = tsnd_pkg::STEP_RESET;
                    outcome_next = tsnd_pkg::OUT_RETRY;
                end
            end
            default:
            begin
                outcome_next = tsnd_pkg::OUT_NONE;
            end
        endcase
    end

    // result word
    always_comb
    begin
        res_next.send_step     = tsnd_pkg::eff_step(step_next, count_next, total_reg);
        res_next.next_index    = count_next;
        res_next.event_outcome = outcome_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg   <= '0;
            session_reg <= '0;
            count_reg   <= '0;
            ready_reg   <= 1'b0;
            step_reg    <= tsnd_pkg::STEP_COMPLETE;
        end
        else
        begin
            if (cfg_wen)
            begin
                total_reg <= cfg_wdata;
            end
            if (ev_take)
            begin
                session_reg <= session_next;
                count_reg   <= count_next;
                ready_reg   <= ready_next;
                step_reg    <= step_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (!res_valid_reg || res_ready)
        begin
            res_valid_reg <= ev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ev_take)
        begin
            res_reg <= res_next;
        end
    end

    `TSND_ASSERT_NOW(a_idle_without_session, session_reg == '0,
        step_reg == tsnd_pkg::STEP_COMPLETE, "step moved without a session")
    `TSND_ASSERT_NOW(a_complete_word,
        res_valid_reg && res_reg.event_outcome == tsnd_pkg::OUT_COMPLETE,
        res_reg.send_step == tsnd_pkg::STEP_COMPLETE, "completion word without complete step")
    `TSND_ASSERT_NEXT(a_refused_keeps_session,
        ev_take && ev.op == tsnd_pkg::OP_START && ev.session_id == '0,
        $stable(session_reg) && $stable(step_reg), "refused start changed the session")
    `TSND_ASSERT_NEXT(a_retry_word, ev_take && res_next.event_outcome == tsnd_pkg::OUT_RETRY,
        step_reg == tsnd_pkg::STEP_RESET && count_reg == '0, "ack retry did not restart")

endmodule

### src/transfer_session_sender.sv
// top level of the transfer session sender
//
//  channel   dir  handshake                 payload
//  s_*       in   s_tvalid / s_tready       tuser op, tdata session, flags, ack count
//  m_*       out  m_tvalid / m_tready       tdata step, next index, outcome
//  cfg_*     in   cfg_wen                   cfg_wdata total entries
//
// one event word a cycle unless m stalls; each word passes the input register then the result register
// m_tvalid is the result register's valid flag, so an s accept reaches m only through both registers
// reset clears the step to complete, the session, counter and ready flag, and total to zero
// a stall on m holds the result word, then the input register fills, then s_tready drops
module transfer_session_sender (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tsnd_pkg::IN_DATA_W-1:0]    s_tdata,  // session_id, source_is_ready,
                                                        // ack_accepted, ack_count
    input  logic [tsnd_pkg::OP_W-1:0]         s_tuser,  // op
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tsnd_pkg::OUT_DATA_W-1:0]   m_tdata,  // send_step, next_index,
                                                        // event_outcome
    input  logic                              cfg_wen,
    input  logic [tsnd_pkg::COUNT_W-1:0]      cfg_wdata
);

    tsnd_pkg::event_t  in_event;
    tsnd_pkg::event_t  ev;
    logic              ev_valid;
    logic              ev_take;
    tsnd_pkg::result_t res;

    assign in_event.op              = s_tuser;
    assign in_event.session_id      = s_tdata[31:0];
    assign in_event.source_is_ready = s_tdata[32];
    assign in_event.ack_accepted    = s_tdata[33];
    assign in_event.ack_count       = s_tdata[49:34];

    assign m_tdata = {2'b00, res};

    tsnd_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_event (in_event),
        .ev_valid (ev_valid),
        .ev_take  (ev_take),
        .ev       (ev)
    );

    tsnd_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .ev_valid  (ev_valid),
        .ev_take   (ev_take),
        .ev        (ev),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

endmodule
